/* rtl/core/smsa_pkg.sv */
// ----------------------------------------------------------------------------
// smsa_pkg
// Shared widths, codes, the stage control word and the saturation helpers of
// the spectral mean/square accumulate unit.
// ----------------------------------------------------------------------------
package smsa_pkg;

  localparam int NUM_BINS_DEF     = 1024;
  localparam int SAMPLE_WIDTH_DEF = 32;

  localparam int BIN_W         = 10;   // bin_index field
  localparam int PORT_SAMPLE_W = 32;   // in_re / in_im fields on the port
  localparam int RES_W         = 64;   // every result field, Q31.32
  localparam int SHIFT_W       = 5;    // weight_shift register
  localparam int TERM_W        = 66;   // clamped correction term
  localparam int WIDE_W        = 128;  // common width for saturation checks

  localparam int IDX_LSB     = 0;
  localparam int RE_LSB      = IDX_LSB + BIN_W;
  localparam int IM_LSB      = RE_LSB + PORT_SAMPLE_W;
  localparam int IN_FIELDS_W = IM_LSB + PORT_SAMPLE_W;
  localparam int IN_TDATA_W  = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = 6 * RES_W;

  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_STEP = 1'b1;

  // Control word that travels with the item through the pipeline stages ahead of the output register.
  typedef struct packed {
    logic             vld;
    logic             step;
    logic             ok;
    logic [BIN_W-1:0] idx;
  } ctl_t;

  // Saturate a sign-extended value to the signed result range.
  function automatic logic signed [RES_W-1:0] sat_res(input logic signed [WIDE_W-1:0] x);
    logic hi_one;
    logic hi_zero;
    hi_one  = &x[WIDE_W-1:RES_W-1];
    hi_zero = ~|x[WIDE_W-1:RES_W-1];
    if (hi_one || hi_zero) begin
      sat_res = x[RES_W-1:0];
    end else if (x[WIDE_W-1]) begin
      sat_res = {1'b1, {(RES_W-1){1'b0}}};
    end else begin
      sat_res = {1'b0, {(RES_W-1){1'b1}}};
    end
  endfunction

  // Clamp a sign-extended value to the correction term range. Anything that
  // reaches a clamp bound drives the accumulator sum into saturation anyway.
  function automatic logic signed [TERM_W-1:0] sat_term(input logic signed [WIDE_W-1:0] x);
    logic hi_one;
    logic hi_zero;
    hi_one  = &x[WIDE_W-1:TERM_W-1];
    hi_zero = ~|x[WIDE_W-1:TERM_W-1];
    if (hi_one || hi_zero) begin
      sat_term = x[TERM_W-1:0];
    end else if (x[WIDE_W-1]) begin
      sat_term = {1'b1, {(TERM_W-1){1'b0}}};
    end else begin
      sat_term = {1'b0, {(TERM_W-1){1'b1}}};
    end
  endfunction

endpackage

/* rtl/core/spectral_mean_square_accumulate_unit.sv */
// ----------------------------------------------------------------------------
// spectral_mean_square_accumulate_unit
// Per-bin spectral step: product, difference square and weighted correction
// accumulate over a stored mean, one bin per clock while the skid entry is free.
// ----------------------------------------------------------------------------
// Items arrive on the s_axis stream. tuser carries the mode: a load stores A
// for the bin and clears its correction sum, a step brings B. Each accepted
// item gives exactly one result transfer on m_axis, in order; a load or a bin
// index beyond the table returns all zeros.
// The weight exponent is written through cfg_write_en / cfg_write_data and
// must only change while no item is in flight.
// Throughput is one item per clock while the skid entry is free, also when
// consecutive items hit the same bin: the mean is read, updated and written
// back inside one stage and the correction sum likewise, each with a one-entry
// write bypass. A result passes in turn the input register, the mean register,
// the product register, the result register and the output register.
// When the receiver stalls, the pipeline keeps advancing until the next result
// lands in the skid entry, and then holds with s_axis_tready low until the
// receiver takes the shown result; nothing is dropped or repeated.
// Reset clears all valid flags and the weight exponent. The memories are not
// cleared, so every bin must be loaded before it is stepped.
// ----------------------------------------------------------------------------
module spectral_mean_square_accumulate_unit #(
  parameter int NUM_BINS     = smsa_pkg::NUM_BINS_DEF,
  parameter int SAMPLE_WIDTH = smsa_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  // Input stream.
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // tdata, low bit up: bin_index[9:0], in_re[41:10], in_im[73:42], zero pad.
  input  logic [smsa_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // tuser: mode[0].
  input  logic [0:0]                         s_axis_tuser,
  // Result stream.
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // tdata, low bit up: product_re, product_im, diffsq_re, diffsq_im,
  // corr_re, corr_im, 64 bits each.
  output logic [smsa_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // Weight exponent register.
  input  logic                               cfg_write_en,
  input  logic [smsa_pkg::SHIFT_W-1:0]       cfg_write_data
);
  import smsa_pkg::*;

  localparam int SW = SAMPLE_WIDTH;

  logic [SHIFT_W-1:0]      weight_shift;
  logic                    en;

  ctl_t                    ctl_1;
  ctl_t                    ctl_2;
  ctl_t                    ctl_3;
  logic signed [SW-1:0]    a_re;
  logic signed [SW-1:0]    a_im;
  logic signed [SW-1:0]    b_re;
  logic signed [SW-1:0]    b_im;
  logic signed [SW:0]      v_re;
  logic signed [SW:0]      v_im;
  logic signed [SW+1:0]    d_minus;
  logic signed [SW+1:0]    d_plus;

  logic signed [RES_W-1:0]  prod_re;
  logic signed [RES_W-1:0]  prod_im;
  logic signed [RES_W-1:0]  dsq_re;
  logic signed [RES_W-1:0]  dsq_im;
  logic signed [TERM_W-1:0] term_re;
  logic signed [TERM_W-1:0] term_im;
  logic signed [RES_W-1:0]  corr_re;
  logic signed [RES_W-1:0]  corr_im;

  always_ff @(posedge clk) begin
    if (rst) begin
      weight_shift <= '0;
    end else if (cfg_write_en) begin
      weight_shift <= cfg_write_data;
    end
  end

  // The whole pipeline moves together while the skid entry is free, so an
  // input transfer completes exactly when the pipeline advances.
  assign s_axis_tready = en;

  smsa_mean_stage #(
    .NUM_BINS     (NUM_BINS),
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_mean (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .in_vld  (s_axis_tvalid),
    .in_mode (s_axis_tuser[0]),
    .in_idx  (s_axis_tdata[IDX_LSB +: BIN_W]),
    .in_b_re (signed'(s_axis_tdata[RE_LSB +: SW])),
    .in_b_im (signed'(s_axis_tdata[IM_LSB +: SW])),
    .ctl     (ctl_1),
    .a_re    (a_re),
    .a_im    (a_im),
    .b_re    (b_re),
    .b_im    (b_im),
    .v_re    (v_re),
    .v_im    (v_im),
    .d_minus (d_minus),
    .d_plus  (d_plus)
  );

  smsa_mul_stage #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_mul (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .weight_shift (weight_shift),
    .ctl_in       (ctl_1),
    .a_re         (a_re),
    .a_im         (a_im),
    .b_re         (b_re),
    .b_im         (b_im),
    .v_re         (v_re),
    .v_im         (v_im),
    .d_minus      (d_minus),
    .d_plus       (d_plus),
    .ctl_mid      (ctl_2),
    .ctl_out      (ctl_3),
    .prod_re      (prod_re),
    .prod_im      (prod_im),
    .dsq_re       (dsq_re),
    .dsq_im       (dsq_im),
    .term_re      (term_re),
    .term_im      (term_im)
  );

  smsa_corr_stage #(
    .NUM_BINS (NUM_BINS)
  ) u_corr (
    .clk     (clk),
    .rst     (rst),
    .en      (en),
    .rd_ctl  (ctl_2),
    .ctl     (ctl_3),
    .term_re (term_re),
    .term_im (term_im),
    .corr_re (corr_re),
    .corr_im (corr_im)
  );

  smsa_skid #(
    .DATA_W (OUT_TDATA_W)
  ) u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (en && ctl_3.vld),
    .push_data ({corr_im, corr_re, dsq_im, dsq_re, prod_im, prod_re}),
    .out_ready (m_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_data  (m_axis_tdata),
    .room      (en)
  );

endmodule

/* rtl/core/smsa_mean_stage.sv */
// ----------------------------------------------------------------------------
// smsa_mean_stage
// Input register, per-bin mean memory with write bypass, and the sum and
// difference terms that feed the multipliers.
// ----------------------------------------------------------------------------
module smsa_mean_stage #(
  parameter int NUM_BINS     = smsa_pkg::NUM_BINS_DEF,
  parameter int SAMPLE_WIDTH = smsa_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          en,
  input  logic                          in_vld,
  input  logic                          in_mode,
  input  logic [smsa_pkg::BIN_W-1:0]    in_idx,
  input  logic signed [SAMPLE_WIDTH-1:0] in_b_re,
  input  logic signed [SAMPLE_WIDTH-1:0] in_b_im,
  output smsa_pkg::ctl_t                ctl,
  output logic signed [SAMPLE_WIDTH-1:0] a_re,
  output logic signed [SAMPLE_WIDTH-1:0] a_im,
  output logic signed [SAMPLE_WIDTH-1:0] b_re,
  output logic signed [SAMPLE_WIDTH-1:0] b_im,
  output logic signed [SAMPLE_WIDTH:0]   v_re,
  output logic signed [SAMPLE_WIDTH:0]   v_im,
  output logic signed [SAMPLE_WIDTH+1:0] d_minus,
  output logic signed [SAMPLE_WIDTH+1:0] d_plus
);
  import smsa_pkg::*;

  localparam int SW     = SAMPLE_WIDTH;
  localparam int ADDR_W = $clog2(NUM_BINS);

  logic [2*SW-1:0]       mem [NUM_BINS];
  logic [2*SW-1:0]       rd;

  ctl_t                  s0;
  logic signed [SW-1:0]  s0_b_re;
  logic signed [SW-1:0]  s0_b_im;

  logic                  fwd_vld;
  logic [ADDR_W-1:0]     fwd_addr;
  logic [2*SW-1:0]       fwd_val;

  logic [ADDR_W-1:0]     in_addr;
  logic [ADDR_W-1:0]     s0_addr;
  logic                  in_ok;
  logic [2*SW-1:0]       cur;
  logic signed [SW-1:0]  ar;
  logic signed [SW-1:0]  ai;
  logic signed [SW:0]    u_re;
  logic signed [SW:0]    u_im;
  logic signed [SW:0]    vr;
  logic signed [SW:0]    vi;
  logic                  wr;
  logic [2*SW-1:0]       wval;

  assign in_addr = ADDR_W'(in_idx);
  assign s0_addr = ADDR_W'(s0.idx);
  assign in_ok   = 32'(in_idx) < 32'(NUM_BINS);

  // The item one stage ahead wrote its bin at the same edge this one read it.
  assign cur = (fwd_vld && (fwd_addr == s0_addr)) ? fwd_val : rd;
  assign ar  = signed'(cur[SW-1:0]);
  assign ai  = signed'(cur[2*SW-1:SW]);

  assign u_re = (SW+1)'(ar) + (SW+1)'(s0_b_re);
  assign u_im = (SW+1)'(ai) + (SW+1)'(s0_b_im);
  assign vr   = (SW+1)'(ar) - (SW+1)'(s0_b_re);
  assign vi   = (SW+1)'(ai) - (SW+1)'(s0_b_im);

  assign wr   = s0.vld && s0.ok;
  assign wval = (s0.step == MODE_STEP) ? {u_im[SW:1], u_re[SW:1]} : {s0_b_im, s0_b_re};

  always_ff @(posedge clk) begin
    if (en) begin
      rd <= mem[in_addr];
      if (wr) begin
        mem[s0_addr] <= wval;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0.vld  <= 1'b0;
      fwd_vld <= 1'b0;
      ctl.vld <= 1'b0;
    end else if (en) begin
      s0.vld   <= in_vld;
      s0.step  <= in_mode;
      s0.ok    <= in_ok;
      s0.idx   <= in_idx;
      s0_b_re  <= in_b_re;
      s0_b_im  <= in_b_im;
      fwd_vld  <= wr;
      fwd_addr <= s0_addr;
      fwd_val  <= wval;
      ctl      <= s0;
      a_re     <= ar;
      a_im     <= ai;
      b_re     <= s0_b_re;
      b_im     <= s0_b_im;
      v_re     <= vr;
      v_im     <= vi;
      d_minus  <= (SW+2)'(vr) - (SW+2)'(vi);
      d_plus   <= (SW+2)'(vr) + (SW+2)'(vi);
    end
  end

endmodule

/* rtl/core/smsa_mul_stage.sv */
// ----------------------------------------------------------------------------
// smsa_mul_stage
// Six parallel products, then the saturated product and square results and
// the weighted correction term.
// ----------------------------------------------------------------------------
module smsa_mul_stage #(
  parameter int SAMPLE_WIDTH = smsa_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic [smsa_pkg::SHIFT_W-1:0]    weight_shift,
  input  smsa_pkg::ctl_t                  ctl_in,
  input  logic signed [SAMPLE_WIDTH-1:0]   a_re,
  input  logic signed [SAMPLE_WIDTH-1:0]   a_im,
  input  logic signed [SAMPLE_WIDTH-1:0]   b_re,
  input  logic signed [SAMPLE_WIDTH-1:0]   b_im,
  input  logic signed [SAMPLE_WIDTH:0]     v_re,
  input  logic signed [SAMPLE_WIDTH:0]     v_im,
  input  logic signed [SAMPLE_WIDTH+1:0]   d_minus,
  input  logic signed [SAMPLE_WIDTH+1:0]   d_plus,
  output smsa_pkg::ctl_t                  ctl_mid,
  output smsa_pkg::ctl_t                  ctl_out,
  output logic signed [smsa_pkg::RES_W-1:0]  prod_re,
  output logic signed [smsa_pkg::RES_W-1:0]  prod_im,
  output logic signed [smsa_pkg::RES_W-1:0]  dsq_re,
  output logic signed [smsa_pkg::RES_W-1:0]  dsq_im,
  output logic signed [smsa_pkg::TERM_W-1:0] term_re,
  output logic signed [smsa_pkg::TERM_W-1:0] term_im
);
  import smsa_pkg::*;

  localparam int SW    = SAMPLE_WIDTH;
  localparam int MAX_S = (1 << SHIFT_W) - 1;
  localparam int SH_W  = 2*SW + 4 + MAX_S;

  logic signed [2*SW-1:0]   p_rr;
  logic signed [2*SW-1:0]   p_ii;
  logic signed [2*SW-1:0]   p_ri;
  logic signed [2*SW-1:0]   p_ir;
  logic signed [2*SW+3:0]   p_sq;
  logic signed [2*SW+1:0]   p_vv;

  logic signed [2*SW:0]     pre;
  logic signed [2*SW:0]     pim;
  logic signed [2*SW+2:0]   v2i;
  logic signed [SH_W-1:0]   sh_re;
  logic signed [SH_W-1:0]   sh_im;
  logic signed [SH_W-1:0]   tr_re;
  logic signed [SH_W-1:0]   tr_im;
  logic                     live;

  assign pre = (2*SW+1)'(p_rr) - (2*SW+1)'(p_ii);
  assign pim = (2*SW+1)'(p_ri) + (2*SW+1)'(p_ir);
  assign v2i = (2*SW+3)'(p_vv) <<< 1;

  // Weighted term floor(V^2 * 2^weight_shift / 4); the shift is exact here.
  assign sh_re = SH_W'(p_sq) <<< weight_shift;
  assign sh_im = SH_W'(v2i) <<< weight_shift;
  assign tr_re = sh_re >>> 2;
  assign tr_im = sh_im >>> 2;

  assign live = (ctl_mid.step == MODE_STEP) && ctl_mid.ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      ctl_mid.vld <= 1'b0;
      ctl_out.vld <= 1'b0;
    end else if (en) begin
      ctl_mid <= ctl_in;
      p_rr    <= a_re * b_re;
      p_ii    <= a_im * b_im;
      p_ri    <= a_re * b_im;
      p_ir    <= a_im * b_re;
      p_sq    <= d_minus * d_plus;
      p_vv    <= v_re * v_im;
      ctl_out <= ctl_mid;
      prod_re <= live ? sat_res(WIDE_W'(pre)) : '0;
      prod_im <= live ? sat_res(WIDE_W'(pim)) : '0;
      dsq_re  <= live ? sat_res(WIDE_W'(p_sq)) : '0;
      dsq_im  <= live ? sat_res(WIDE_W'(v2i)) : '0;
      term_re <= sat_term(WIDE_W'(tr_re));
      term_im <= sat_term(WIDE_W'(tr_im));
    end
  end

endmodule

/* rtl/core/smsa_corr_stage.sv */
// ----------------------------------------------------------------------------
// smsa_corr_stage
// Per-bin correction accumulator memory with write bypass and the
// saturating accumulate.
// ----------------------------------------------------------------------------
module smsa_corr_stage #(
  parameter int NUM_BINS = smsa_pkg::NUM_BINS_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               en,
  input  smsa_pkg::ctl_t                     rd_ctl,
  input  smsa_pkg::ctl_t                     ctl,
  input  logic signed [smsa_pkg::TERM_W-1:0] term_re,
  input  logic signed [smsa_pkg::TERM_W-1:0] term_im,
  output logic signed [smsa_pkg::RES_W-1:0]  corr_re,
  output logic signed [smsa_pkg::RES_W-1:0]  corr_im
);
  import smsa_pkg::*;

  localparam int ADDR_W = $clog2(NUM_BINS);

  logic [2*RES_W-1:0]        mem [NUM_BINS];
  logic [2*RES_W-1:0]        rd;

  logic                      fwd_vld;
  logic [ADDR_W-1:0]         fwd_addr;
  logic [2*RES_W-1:0]        fwd_val;

  logic [ADDR_W-1:0]         addr;
  logic [2*RES_W-1:0]        cur;
  logic signed [TERM_W:0]    sum_re;
  logic signed [TERM_W:0]    sum_im;
  logic signed [RES_W-1:0]   new_re;
  logic signed [RES_W-1:0]   new_im;
  logic                      live;
  logic                      wr;
  logic [2*RES_W-1:0]        wval;

  assign addr = ADDR_W'(ctl.idx);
  assign cur  = (fwd_vld && (fwd_addr == addr)) ? fwd_val : rd;

  assign sum_re = (TERM_W+1)'(term_re) + (TERM_W+1)'(signed'(cur[RES_W-1:0]));
  assign sum_im = (TERM_W+1)'(term_im) + (TERM_W+1)'(signed'(cur[2*RES_W-1:RES_W]));
  assign new_re = sat_res(WIDE_W'(sum_re));
  assign new_im = sat_res(WIDE_W'(sum_im));

  // A load clears the bin; a step stores the new sum.
  assign live = (ctl.step == MODE_STEP) && ctl.ok;
  assign wr   = ctl.vld && ctl.ok;
  assign wval = live ? {new_im, new_re} : '0;

  assign corr_re = live ? new_re : '0;
  assign corr_im = live ? new_im : '0;

  always_ff @(posedge clk) begin
    if (en) begin
      rd <= mem[ADDR_W'(rd_ctl.idx)];
      if (wr) begin
        mem[addr] <= wval;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_vld <= 1'b0;
    end else if (en) begin
      fwd_vld  <= wr;
      fwd_addr <= addr;
      fwd_val  <= wval;
    end
  end

endmodule

/* rtl/core/smsa_skid.sv */
// ----------------------------------------------------------------------------
// smsa_skid
// Output register with one skid entry, so the pipeline keeps moving after the
// receiver stalls until a result lands in the skid entry.
// ----------------------------------------------------------------------------
module smsa_skid #(
  parameter int DATA_W = smsa_pkg::OUT_TDATA_W
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              out_ready,
  output logic              out_valid,
  output logic [DATA_W-1:0] out_data,
  output logic              room
);

  logic              skid_vld;
  logic [DATA_W-1:0] skid_data;

  assign room = !skid_vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_vld  <= 1'b0;
    end else begin
      if (!out_valid || out_ready) begin
        if (skid_vld) begin
          out_valid <= 1'b1;
          out_data  <= skid_data;
          skid_vld  <= 1'b0;
        end else begin
          out_valid <= push;
          if (push) begin
            out_data <= push_data;
          end
        end
      end else if (push) begin
        skid_vld  <= 1'b1;
        skid_data <= push_data;
      end
    end
  end

endmodule

/* rtl/core/smsa_checker.sv */
// ----------------------------------------------------------------------------
// smsa_checker
// Port-level checks of the unit's stall behavior and latency.
// ----------------------------------------------------------------------------
module smsa_checker (
  input logic                             clk,
  input logic                             rst,
  input logic                             s_axis_tvalid,
  input logic                             s_axis_tready,
  input logic                             m_axis_tvalid,
  input logic                             m_axis_tready,
  input logic [smsa_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

  // No result is shown in the cycle after reset.
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("result valid right after reset");

  // A stalled result holds its value.
  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

  // Input back-pressure only follows a stalled output.
  a_ready_cause: assert property (@(posedge clk) disable iff (rst)
    !s_axis_tready |-> $past(m_axis_tvalid && !m_axis_tready))
    else $error("input stalled without an output stall");

  // When the receiver is ready, the skid entry drains and the input is ready in the next cycle.
  a_ready_returns: assert property (@(posedge clk) disable iff (rst)
    m_axis_tready |=> s_axis_tready)
    else $error("input still stalled after output was taken");

  // With the receiver ready, an accepted item shows up on m_axis after passing the pipeline registers.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && m_axis_tready) ##1 m_axis_tready
      ##1 m_axis_tready ##1 m_axis_tready |-> ##2 m_axis_tvalid)
    else $error("result missing after pipeline latency");

endmodule

bind spectral_mean_square_accumulate_unit smsa_checker u_smsa_checker (.*);
